// ----- src/hufd_pkg.sv -----
`default_nettype none

package hufd_pkg;

    localparam int MAX_FRAME_BYTES = 320;
    localparam int MIN_FRAME_BYTES = 13;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 2);
    localparam int HEAD_DEPTH      = 9;
    localparam int HEAD_IDX_W      = $clog2(HEAD_DEPTH);
    localparam int TAIL_DEPTH      = 5;
    localparam int FIFO_DEPTH      = 2;
    localparam int FIFO_PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_LAST_MIN   = POS_W'(MIN_FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_FEED_FIRST = POS_W'(MIN_FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_MAX        = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_HEAD_END   = POS_W'(HEAD_DEPTH);

    localparam logic [7:0] SOF_BYTE   = 8'hEE;
    localparam logic [7:0] RTC_CMD    = 8'hF7;
    localparam logic [7:0] NOTIFY_CMD = 8'hB1;
    localparam logic [7:0] TEXT_SUB   = 8'h11;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] NUL_BYTE   = 8'h00;

    localparam logic [19:0] NUM_MAX   = 20'd65535;
    localparam logic [11:0] YEAR_BASE = 12'd2000;

    localparam logic [15:0] QUERY_YEAR_RST   = 16'd2026;
    localparam logic [7:0]  QUERY_MONTH_RST  = 8'd5;
    localparam logic [7:0]  QUERY_DAY_RST    = 8'd6;
    localparam logic [7:0]  QUERY_HOUR_RST   = 8'd16;
    localparam logic [7:0]  QUERY_MINUTE_RST = 8'd46;

    localparam logic [15:0] CTRL_YEAR   = 16'd2;
    localparam logic [15:0] CTRL_MONTH  = 16'd3;
    localparam logic [15:0] CTRL_DAY    = 16'd4;
    localparam logic [15:0] CTRL_HOUR   = 16'd5;
    localparam logic [15:0] CTRL_MINUTE = 16'd6;

    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_IDX_LSB  = 2;
    localparam logic [CFG_ADDR_W-CFG_IDX_LSB-1:0] REG_SCREEN_FILTER = '0;

    typedef enum logic [1:0] {
        KIND_IGNORE,
        KIND_RTC,
        KIND_NOTIFY
    } t_kind;

    typedef enum logic [1:0] {
        ST_IGNORED = 2'd0,
        ST_RTC     = 2'd1,
        ST_QUERY   = 2'd2,
        ST_OTHER   = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] acc;
        logic        invalid;
    } t_num;

    typedef struct packed {
        logic       ok;
        logic [6:0] value;
    } t_bcd;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [15:0] control;
        t_num        num;
        logic [7:0]  last;
        logic        short_text;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic t_num f_feed_digit(t_num cur, logic [7:0] b);
        t_num        r;
        logic [19:0] sum;
        r   = cur;
        sum = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {16'd0, b[3:0]};
        if (!cur.invalid) begin
            if (b < ASCII_ZERO || b > ASCII_NINE) begin
                r.invalid = 1'b1;
            end else if (sum > NUM_MAX) begin
                r.invalid = 1'b1;
            end else begin
                r.acc = sum[15:0];
            end
        end
        return r;
    endfunction

    function automatic t_bcd f_bcd(logic [7:0] b);
        t_bcd r;
        r.ok    = (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
        r.value = {b[7:4], 3'b000} + {2'b00, b[7:4], 1'b0} + {3'b000, b[3:0]};
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/hufd_if.sv -----
`default_nettype none

interface hufd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface hufd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [15:0] query_year_out;
    logic [7:0]  query_month_out;
    logic [7:0]  query_day_out;
    logic [7:0]  query_hour_out;
    logic [7:0]  query_minute_out;
    logic [11:0] rtc_year_out;
    logic [3:0]  rtc_month_out;
    logic [4:0]  rtc_day_out;
    logic [4:0]  rtc_hour_out;
    logic [5:0]  rtc_minute_out;
    logic [5:0]  rtc_second_out;

    modport source (
        output valid, frame_status, query_year_out, query_month_out, query_day_out,
               query_hour_out, query_minute_out, rtc_year_out, rtc_month_out,
               rtc_day_out, rtc_hour_out, rtc_minute_out, rtc_second_out,
        input  ready
    );
    modport sink (
        input  valid, frame_status, query_year_out, query_month_out, query_day_out,
               query_hour_out, query_minute_out, rtc_year_out, rtc_month_out,
               rtc_day_out, rtc_hour_out, rtc_minute_out, rtc_second_out,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/hufd_front.sv -----
`default_nettype none

module hufd_front import hufd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    hufd_in_if.sink         i_in,
    input  wire logic [15:0] i_screen_filter,
    input  wire t_fifo_stat i_fifo_stat,
    output logic            o_push,
    output t_entry          o_entry
);

    localparam logic [6:0] MONTH_MAX  = 7'd12;
    localparam logic [6:0] DAY_MAX    = 7'd31;
    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] MINUTE_MAX = 7'd59;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    t_num             r_num;
    t_num             n_num;
    logic [7:0]       r_head [HEAD_DEPTH];
    logic [7:0]       r_tail [TAIL_DEPTH];

    logic w_accept;
    logic w_feed;
    logic w_len_ok;
    logic w_rtc_ok;
    logic w_notify_ok;
    t_bcd w_bcd_year;
    t_bcd w_bcd_month;
    t_bcd w_bcd_day;
    t_bcd w_bcd_hour;
    t_bcd w_bcd_minute;
    t_bcd w_bcd_second;

    assign i_in.ready = !i_fifo_stat.full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign o_push     = w_accept && i_in.frame_end;

    always_comb begin
        w_feed = (r_pos >= POS_FEED_FIRST) && (r_pos <= POS_MAX);
        n_num  = w_feed ? f_feed_digit(r_num, r_tail[0]) : r_num;
        n_pos  = (r_pos <= POS_MAX) ? r_pos + 1'b1 : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_num <= '0;
        end else if (w_accept) begin
            r_pos <= i_in.frame_end ? '0 : n_pos;
            r_num <= i_in.frame_end ? '0 : n_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (r_pos < POS_HEAD_END) begin
                r_head[r_pos[HEAD_IDX_W-1:0]] <= i_in.frame_byte;
            end
            for (int i = 0; i < TAIL_DEPTH - 1; i++) begin
                r_tail[i] <= r_tail[i+1];
            end
            r_tail[TAIL_DEPTH-1] <= i_in.frame_byte;
        end
    end

    always_comb begin
        w_bcd_year   = f_bcd(r_head[2]);
        w_bcd_month  = f_bcd(r_head[3]);
        w_bcd_day    = f_bcd(r_head[5]);
        w_bcd_hour   = f_bcd(r_head[6]);
        w_bcd_minute = f_bcd(r_head[7]);
        w_bcd_second = f_bcd(r_head[8]);

        w_len_ok = (r_pos >= POS_LAST_MIN) && (r_pos < POS_MAX);

        w_rtc_ok = (r_pos == POS_LAST_MIN) && (r_head[0] == SOF_BYTE)
                && w_bcd_year.ok && w_bcd_month.ok && w_bcd_day.ok
                && w_bcd_hour.ok && w_bcd_minute.ok && w_bcd_second.ok
                && (w_bcd_month.value >= 7'd1) && (w_bcd_month.value <= MONTH_MAX)
                && (w_bcd_day.value >= 7'd1) && (w_bcd_day.value <= DAY_MAX)
                && (w_bcd_hour.value <= HOUR_MAX)
                && (w_bcd_minute.value <= MINUTE_MAX)
                && (w_bcd_second.value <= MINUTE_MAX);

        w_notify_ok = (r_head[0] == SOF_BYTE) && (r_head[1] == NOTIFY_CMD)
                   && (r_head[2] == TEXT_SUB) && (r_head[7] == TEXT_SUB)
                   && ({r_head[3], r_head[4]} == i_screen_filter);

        if (!w_len_ok) begin
            o_entry.kind = KIND_IGNORE;
        end else if (r_head[1] == RTC_CMD) begin
            o_entry.kind = w_rtc_ok ? KIND_RTC : KIND_IGNORE;
        end else begin
            o_entry.kind = w_notify_ok ? KIND_NOTIFY : KIND_IGNORE;
        end

        o_entry.year       = w_bcd_year.value;
        o_entry.month      = w_bcd_month.value[3:0];
        o_entry.day        = w_bcd_day.value[4:0];
        o_entry.hour       = w_bcd_hour.value[4:0];
        o_entry.minute     = w_bcd_minute.value[5:0];
        o_entry.second     = w_bcd_second.value[5:0];
        o_entry.control    = {r_head[5], r_head[6]};
        o_entry.num        = n_num;
        o_entry.last       = r_tail[1];
        o_entry.short_text = (r_pos == POS_LAST_MIN);
    end

endmodule

`default_nettype wire

// ----- src/hufd_fifo.sv -----
`default_nettype none

module hufd_fifo import hufd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_entry,
    output t_fifo_stat  o_stat
);

    localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);
    localparam logic [FIFO_CNT_W-1:0] CNT_FULL = FIFO_CNT_W'(FIFO_DEPTH);

    t_entry                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_entry      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ----- src/hufd_back.sv -----
`default_nettype none

module hufd_back import hufd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_fifo_stat i_fifo_stat,
    input  wire t_entry     i_entry,
    output logic            o_pop,
    hufd_out_if.source      o_out
);

    logic        r_out_valid;
    t_status     r_status;
    t_status     n_status;
    logic [15:0] r_query_year;
    logic [15:0] n_query_year;
    logic [7:0]  r_query_month;
    logic [7:0]  n_query_month;
    logic [7:0]  r_query_day;
    logic [7:0]  n_query_day;
    logic [7:0]  r_query_hour;
    logic [7:0]  n_query_hour;
    logic [7:0]  r_query_minute;
    logic [7:0]  n_query_minute;
    logic [11:0] r_rtc_year;
    logic [11:0] n_rtc_year;
    logic [3:0]  r_rtc_month;
    logic [3:0]  n_rtc_month;
    logic [4:0]  r_rtc_day;
    logic [4:0]  n_rtc_day;
    logic [4:0]  r_rtc_hour;
    logic [4:0]  n_rtc_hour;
    logic [5:0]  r_rtc_minute;
    logic [5:0]  n_rtc_minute;
    logic [5:0]  r_rtc_second;
    logic [5:0]  n_rtc_second;

    t_num w_num;
    logic w_num_ok;

    assign o_pop = !i_fifo_stat.empty && (!r_out_valid || o_out.ready);

    always_comb begin
        w_num    = (i_entry.last != NUL_BYTE) ? f_feed_digit(i_entry.num, i_entry.last)
                                              : i_entry.num;
        w_num_ok = !w_num.invalid && !(i_entry.short_text && (i_entry.last == NUL_BYTE));

        n_status       = ST_IGNORED;
        n_query_year   = r_query_year;
        n_query_month  = r_query_month;
        n_query_day    = r_query_day;
        n_query_hour   = r_query_hour;
        n_query_minute = r_query_minute;
        n_rtc_year     = r_rtc_year;
        n_rtc_month    = r_rtc_month;
        n_rtc_day      = r_rtc_day;
        n_rtc_hour     = r_rtc_hour;
        n_rtc_minute   = r_rtc_minute;
        n_rtc_second   = r_rtc_second;

        unique case (i_entry.kind)
            KIND_RTC: begin
                n_status     = ST_RTC;
                n_rtc_year   = YEAR_BASE + {5'd0, i_entry.year};
                n_rtc_month  = i_entry.month;
                n_rtc_day    = i_entry.day;
                n_rtc_hour   = i_entry.hour;
                n_rtc_minute = i_entry.minute;
                n_rtc_second = i_entry.second;
            end
            KIND_NOTIFY: begin
                if (w_num_ok) begin
                    n_status = ST_QUERY;
                    unique case (i_entry.control)
                        CTRL_YEAR:   n_query_year   = w_num.acc;
                        CTRL_MONTH:  n_query_month  = w_num.acc[7:0];
                        CTRL_DAY:    n_query_day    = w_num.acc[7:0];
                        CTRL_HOUR:   n_query_hour   = w_num.acc[7:0];
                        CTRL_MINUTE: n_query_minute = w_num.acc[7:0];
                        default:     n_status       = ST_OTHER;
                    endcase
                end
            end
            default: begin
                n_status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_status       <= ST_IGNORED;
            r_query_year   <= QUERY_YEAR_RST;
            r_query_month  <= QUERY_MONTH_RST;
            r_query_day    <= QUERY_DAY_RST;
            r_query_hour   <= QUERY_HOUR_RST;
            r_query_minute <= QUERY_MINUTE_RST;
            r_rtc_year     <= '0;
            r_rtc_month    <= '0;
            r_rtc_day      <= '0;
            r_rtc_hour     <= '0;
            r_rtc_minute   <= '0;
            r_rtc_second   <= '0;
        end else if (o_pop) begin
            r_out_valid    <= 1'b1;
            r_status       <= n_status;
            r_query_year   <= n_query_year;
            r_query_month  <= n_query_month;
            r_query_day    <= n_query_day;
            r_query_hour   <= n_query_hour;
            r_query_minute <= n_query_minute;
            r_rtc_year     <= n_rtc_year;
            r_rtc_month    <= n_rtc_month;
            r_rtc_day      <= n_rtc_day;
            r_rtc_hour     <= n_rtc_hour;
            r_rtc_minute   <= n_rtc_minute;
            r_rtc_second   <= n_rtc_second;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.frame_status     = r_status;
    assign o_out.query_year_out   = r_query_year;
    assign o_out.query_month_out  = r_query_month;
    assign o_out.query_day_out    = r_query_day;
    assign o_out.query_hour_out   = r_query_hour;
    assign o_out.query_minute_out = r_query_minute;
    assign o_out.rtc_year_out     = r_rtc_year;
    assign o_out.rtc_month_out    = r_rtc_month;
    assign o_out.rtc_day_out      = r_rtc_day;
    assign o_out.rtc_hour_out     = r_rtc_hour;
    assign o_out.rtc_minute_out   = r_rtc_minute;
    assign o_out.rtc_second_out   = r_rtc_second;

endmodule

`default_nettype wire

// ----- src/hmi_uplink_frame_decoder_unit.sv -----
// The result of a frame is stored in the frame queue and then in the output register.
// Throughput: one byte per cycle; the two-entry frame queue stalls input only when it is full.
// The output register holds each result until it is taken; the queue keeps bytes flowing.
// Reset is synchronous and active low: it clears the byte count, the queue and the output,
// sets the query registers to 2026-05-06 16:46 and the stored RTC time and screen filter to zero.
`default_nettype none

module hmi_uplink_frame_decoder_unit import hufd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    hufd_in_if.sink                    i_in,
    hufd_out_if.source                 o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    logic [15:0] r_screen_filter;
    logic        w_sel_filter;
    logic        w_push;
    logic        w_pop;
    t_entry      w_push_entry;
    t_entry      w_pop_entry;
    t_fifo_stat  w_fifo_stat;

    assign pready       = 1'b1;
    assign w_sel_filter = (paddr[CFG_ADDR_W-1:CFG_IDX_LSB] == REG_SCREEN_FILTER);
    assign prdata       = w_sel_filter ? {16'd0, r_screen_filter} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_filter <= '0;
        end else if (psel && penable && pwrite && pready && w_sel_filter) begin
            r_screen_filter <= pwdata[15:0];
        end
    end

    hufd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_screen_filter (r_screen_filter),
        .i_fifo_stat     (w_fifo_stat),
        .o_push          (w_push),
        .o_entry         (w_push_entry)
    );

    hufd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_pop_entry),
        .o_stat  (w_fifo_stat)
    );

    hufd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo_stat (w_fifo_stat),
        .i_entry     (w_pop_entry),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    a_frame_end_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.frame_end) |=> !w_fifo_stat.empty)
        else $error("completed frame did not reach the queue");

    a_rtc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.frame_status == ST_RTC)) |->
            (o_out.rtc_year_out >= 12'd2000) && (o_out.rtc_year_out <= 12'd2099)
            && (o_out.rtc_month_out >= 4'd1) && (o_out.rtc_month_out <= 4'd12)
            && (o_out.rtc_day_out >= 5'd1) && (o_out.rtc_hour_out <= 5'd23)
            && (o_out.rtc_minute_out <= 6'd59) && (o_out.rtc_second_out <= 6'd59))
        else $error("stored RTC time out of range");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hufd_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES   = 65;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } uplink_item_t;

    typedef struct packed {
        t_status     status;
        logic [15:0] q_year;
        logic [7:0]  q_month;
        logic [7:0]  q_day;
        logic [7:0]  q_hour;
        logic [7:0]  q_minute;
        logic [11:0] r_year;
        logic [3:0]  r_month;
        logic [4:0]  r_day;
        logic [4:0]  r_hour;
        logic [5:0]  r_minute;
        logic [5:0]  r_second;
    } frame_verdict_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    hufd_in_if  in_if ();
    hufd_out_if out_if ();

    hmi_uplink_frame_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    uplink_item_t   uplink_bytes[$];
    frame_verdict_t frame_verdicts[$];
    logic [7:0]     frame_buf[$];

    int mismatches;
    int cycle_count;
    int calm_left;
    int send_idle_pct;
    int recv_stall_pct;
    int bytes_queued;
    int frames_queued;
    int bytes_taken;
    int status_seen [4];

    // Decoder state as the block should hold it.
    logic [8:0]  frame_pos;
    logic [7:0]  head_seen [9];
    logic [7:0]  tail_seen [5];
    logic [19:0] text_value;
    logic        text_bad;
    logic [15:0] q_year;
    logic [7:0]  q_month;
    logic [7:0]  q_day;
    logic [7:0]  q_hour;
    logic [7:0]  q_minute;
    logic [11:0] clk_year;
    logic [3:0]  clk_month;
    logic [4:0]  clk_day;
    logic [4:0]  clk_hour;
    logic [5:0]  clk_minute;
    logic [5:0]  clk_second;
    logic [15:0] filter_now;

    function automatic void reset_decoder();
        frame_pos  = '0;
        foreach (head_seen[i]) head_seen[i] = '0;
        foreach (tail_seen[i]) tail_seen[i] = '0;
        text_value = '0;
        text_bad   = 1'b0;
        q_year     = 16'd2026;
        q_month    = 8'd5;
        q_day      = 8'd6;
        q_hour     = 8'd16;
        q_minute   = 8'd46;
        clk_year   = '0;
        clk_month  = '0;
        clk_day    = '0;
        clk_hour   = '0;
        clk_minute = '0;
        clk_second = '0;
        filter_now = '0;
    endfunction

    function automatic void take_text_char(input logic [7:0] b);
        if (!text_bad) begin
            if (b < ASCII_ZERO || b > ASCII_NINE) begin
                text_bad = 1'b1;
            end else begin
                text_value = text_value * 10 + {12'd0, b - ASCII_ZERO};
                if (text_value > 20'd65535) begin
                    text_value = 20'd65536;
                    text_bad   = 1'b1;
                end
            end
        end
    endfunction

    function automatic bit bcd_decode(input logic [7:0] b, output logic [6:0] v);
        v = 7'(b[7:4] * 10 + b[3:0]);
        return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
    endfunction

    function automatic t_status judge_rtc(input int unsigned len);
        logic [6:0] y, mo, d, h, mi, s;
        bit ok;
        if (len != 13 || head_seen[0] != SOF_BYTE) begin
            return ST_IGNORED;
        end
        ok = bcd_decode(head_seen[2], y);
        ok = bcd_decode(head_seen[3], mo) && ok;
        ok = bcd_decode(head_seen[5], d) && ok;
        ok = bcd_decode(head_seen[6], h) && ok;
        ok = bcd_decode(head_seen[7], mi) && ok;
        ok = bcd_decode(head_seen[8], s) && ok;
        if (!ok) begin
            return ST_IGNORED;
        end
        if (mo < 1 || mo > 12 || d < 1 || d > 31 || h > 23 || mi > 59 || s > 59) begin
            return ST_IGNORED;
        end
        clk_year   = 12'd2000 + 12'(y);
        clk_month  = 4'(mo);
        clk_day    = 5'(d);
        clk_hour   = 5'(h);
        clk_minute = 6'(mi);
        clk_second = 6'(s);
        return ST_RTC;
    endfunction

    function automatic t_status judge_notify(input int unsigned len);
        logic [15:0] screen;
        logic [15:0] control;
        int unsigned text_len;
        if (len < 13) begin
            return ST_IGNORED;
        end
        if (head_seen[0] != SOF_BYTE || head_seen[1] != NOTIFY_CMD ||
            head_seen[2] != TEXT_SUB || head_seen[7] != TEXT_SUB) begin
            return ST_IGNORED;
        end
        screen  = {head_seen[3], head_seen[4]};
        control = {head_seen[5], head_seen[6]};
        if (screen != filter_now) begin
            return ST_IGNORED;
        end
        text_len = len - 12;
        if (tail_seen[0] == NUL_BYTE) begin
            text_len--;
        end else begin
            take_text_char(tail_seen[0]);
        end
        if (text_len == 0 || text_bad) begin
            return ST_IGNORED;
        end
        case (control)
            CTRL_YEAR:   q_year   = text_value[15:0];
            CTRL_MONTH:  q_month  = text_value[7:0];
            CTRL_DAY:    q_day    = text_value[7:0];
            CTRL_HOUR:   q_hour   = text_value[7:0];
            CTRL_MINUTE: q_minute = text_value[7:0];
            default:     return ST_OTHER;
        endcase
        return ST_QUERY;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic fin,
                                       output frame_verdict_t v);
        int unsigned len;
        t_status     st;
        if (frame_pos < 9) begin
            head_seen[frame_pos] = b;
        end
        if (frame_pos >= 13 && frame_pos <= MAX_FRAME_BYTES) begin
            take_text_char(tail_seen[0]);
        end
        for (int i = 0; i < 4; i++) begin
            tail_seen[i] = tail_seen[i+1];
        end
        tail_seen[4] = b;
        len = frame_pos + 1;
        if (frame_pos <= MAX_FRAME_BYTES) begin
            frame_pos = frame_pos + 1;
        end
        if (!fin) begin
            return 1'b0;
        end
        st = ST_IGNORED;
        if (len <= MAX_FRAME_BYTES) begin
            if (len > 1 && head_seen[1] == RTC_CMD) begin
                st = judge_rtc(len);
            end else begin
                st = judge_notify(len);
            end
        end
        frame_pos  = '0;
        text_value = '0;
        text_bad   = 1'b0;
        v.status   = st;
        v.q_year   = q_year;
        v.q_month  = q_month;
        v.q_day    = q_day;
        v.q_hour   = q_hour;
        v.q_minute = q_minute;
        v.r_year   = clk_year;
        v.r_month  = clk_month;
        v.r_day    = clk_day;
        v.r_hour   = clk_hour;
        v.r_minute = clk_minute;
        v.r_second = clk_second;
        return 1'b1;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Each accepted byte is predicted at the edge that accepts it.
    always @(posedge i_clk) begin : drive_uplink
        frame_verdict_t verdict;
        uplink_item_t   item;
        bit             send_gap;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                bytes_taken++;
                if (decode_byte(in_if.frame_byte, in_if.frame_end, verdict)) begin
                    frame_verdicts.push_back(verdict);
                end
            end
            if (!in_if.valid || in_if.ready) begin
                send_gap = (calm_left == 0) && ($urandom_range(99) < send_idle_pct);
                if (uplink_bytes.size() != 0 && !send_gap) begin
                    item = uplink_bytes.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.frame_byte <= item.b;
                    in_if.frame_end  <= item.fin;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= !((calm_left == 0) && ($urandom_range(99) < recv_stall_pct));
        end
    end

    always @(posedge i_clk) begin : check_results
        frame_verdict_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            status_seen[out_if.frame_status]++;
            if (frame_verdicts.size() == 0) begin
                $display("%0t: result transaction with no frame pending, status %0d",
                         $time, out_if.frame_status);
                mismatches++;
            end else begin
                want = frame_verdicts.pop_front();
                check_field("frame_status", want.status, out_if.frame_status);
                check_field("query_year", want.q_year, out_if.query_year_out);
                check_field("query_month", want.q_month, out_if.query_month_out);
                check_field("query_day", want.q_day, out_if.query_day_out);
                check_field("query_hour", want.q_hour, out_if.query_hour_out);
                check_field("query_minute", want.q_minute, out_if.query_minute_out);
                check_field("rtc_year", want.r_year, out_if.rtc_year_out);
                check_field("rtc_month", want.r_month, out_if.rtc_month_out);
                check_field("rtc_day", want.r_day, out_if.rtc_day_out);
                check_field("rtc_hour", want.r_hour, out_if.rtc_hour_out);
                check_field("rtc_minute", want.r_minute, out_if.rtc_minute_out);
                check_field("rtc_second", want.r_second, out_if.rtc_second_out);
            end
        end
    end

    // Short calm stretches switch all idling off for a while.
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d frames outstanding", $time,
                     frame_verdicts.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            cycle_count <= cycle_count + 1;
            if (calm_left != 0) begin
                calm_left <= calm_left - 1;
            end else if ($urandom_range(63) == 0) begin
                calm_left <= $urandom_range(40, 10);
            end
        end
    end

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    task automatic commit_frame();
        uplink_item_t it;
        for (int i = 0; i < frame_buf.size(); i++) begin
            it.b   = frame_buf[i];
            it.fin = (i == frame_buf.size() - 1);
            uplink_bytes.push_back(it);
        end
        bytes_queued += frame_buf.size();
        frames_queued++;
        frame_buf.delete();
    endtask

    task automatic add_head(input logic [15:0] screen, input logic [15:0] control);
        frame_buf.push_back(SOF_BYTE);
        frame_buf.push_back(NOTIFY_CMD);
        frame_buf.push_back(TEXT_SUB);
        frame_buf.push_back(screen[15:8]);
        frame_buf.push_back(screen[7:0]);
        frame_buf.push_back(control[15:8]);
        frame_buf.push_back(control[7:0]);
        frame_buf.push_back(TEXT_SUB);
    endtask

    task automatic add_tail();
        if ($urandom_range(1) == 0) begin
            frame_buf.push_back(8'hFF);
            frame_buf.push_back(8'hFC);
            frame_buf.push_back(8'hFF);
            frame_buf.push_back(8'hFF);
        end else begin
            repeat (4) frame_buf.push_back(8'($urandom));
        end
    endtask

    task automatic add_number(input int unsigned v, input int unsigned zeros);
        logic [7:0] digits[$];
        repeat (zeros) frame_buf.push_back(ASCII_ZERO);
        do begin
            digits.push_front(ASCII_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) frame_buf.push_back(digits[i]);
    endtask

    task automatic notify_frame(input logic [15:0] screen, input logic [15:0] control,
                                input int unsigned v, input int unsigned zeros,
                                input bit nul);
        add_head(screen, control);
        add_number(v, zeros);
        if (nul) begin
            frame_buf.push_back(NUL_BYTE);
        end
        add_tail();
        commit_frame();
    endtask

    task automatic rtc_frame(input logic [7:0] sof, y, mo, wd, d, h, mi, s,
                             input int delta);
        frame_buf.push_back(sof);
        frame_buf.push_back(RTC_CMD);
        frame_buf.push_back(y);
        frame_buf.push_back(mo);
        frame_buf.push_back(wd);
        frame_buf.push_back(d);
        frame_buf.push_back(h);
        frame_buf.push_back(mi);
        frame_buf.push_back(s);
        add_tail();
        if (delta > 0) begin
            frame_buf.push_back(8'($urandom));
        end else if (delta < 0) begin
            void'(frame_buf.pop_back());
        end
        commit_frame();
    endtask

    task automatic long_notify(input int unsigned total);
        add_head(filter_now, CTRL_MINUTE);
        repeat (total - 13) frame_buf.push_back(ASCII_ZERO);
        frame_buf.push_back(ASCII_ZERO + 8'($urandom_range(9, 1)));
        add_tail();
        commit_frame();
    endtask

    task automatic random_rtc();
        logic [7:0] sof, y, mo, wd, d, h, mi, s;
        int delta;
        sof   = SOF_BYTE;
        y     = to_bcd($urandom_range(99));
        mo    = to_bcd($urandom_range(12, 1));
        wd    = 8'($urandom);
        d     = to_bcd($urandom_range(31, 1));
        h     = to_bcd($urandom_range(23));
        mi    = to_bcd($urandom_range(59));
        s     = to_bcd($urandom_range(59));
        delta = 0;
        if ($urandom_range(99) < 30) begin
            case ($urandom_range(9))
                0: mo = ($urandom_range(1) == 0) ? 8'h00 : to_bcd($urandom_range(99, 13));
                1: d = ($urandom_range(1) == 0) ? 8'h00 : to_bcd($urandom_range(99, 32));
                2: h = to_bcd($urandom_range(99, 24));
                3: mi = to_bcd($urandom_range(99, 60));
                4: s = to_bcd($urandom_range(99, 60));
                5: y = {4'($urandom_range(15, 10)), y[3:0]};
                6: mo = {mo[7:4], 4'($urandom_range(15, 10))};
                7: s = {s[7:4], 4'($urandom_range(15, 10))};
                8: sof = 8'($urandom);
                default: delta = ($urandom_range(1) == 0) ? 1 : -1;
            endcase
        end
        rtc_frame(sof, y, mo, wd, d, h, mi, s, delta);
    endtask

    task automatic random_notify();
        logic [15:0] screen;
        logic [15:0] control;
        int unsigned r;
        int unsigned zeros;
        int unsigned text_start;
        screen = ($urandom_range(99) < 85) ? filter_now : 16'($urandom);
        r = $urandom_range(99);
        if (r < 70) begin
            control = 16'($urandom_range(6, 2));
        end else if (r < 76) begin
            control = 16'd0;
        end else if (r < 82) begin
            control = 16'd1;
        end else if (r < 88) begin
            control = 16'd7;
        end else if (r < 92) begin
            control = 16'hFFFF;
        end else begin
            control = 16'($urandom);
        end
        add_head(screen, control);
        if ($urandom_range(99) < 8) begin
            case ($urandom_range(3))
                0: frame_buf[0] = 8'($urandom);
                1: frame_buf[1] = 8'($urandom);
                2: frame_buf[2] = 8'($urandom);
                default: frame_buf[7] = 8'($urandom);
            endcase
        end
        text_start = frame_buf.size();
        zeros = ($urandom_range(99) < 15) ? $urandom_range(4, 1) : 0;
        r = $urandom_range(99);
        if (r < 45) begin
            add_number($urandom_range(65535), zeros);
        end else if (r < 65) begin
            add_number($urandom_range(99), zeros);
        end else if (r < 69) begin
            add_number($urandom_range(65545, 65530), zeros);
        end else if (r < 73) begin
            add_number($urandom_range(9999999, 65536), zeros);
        end else if (r < 80) begin
            zeros = 0;
        end else if (r < 92) begin
            add_number($urandom_range(65535), zeros);
            frame_buf[$urandom_range(frame_buf.size() - 1, text_start)] = 8'($urandom);
        end else begin
            repeat ($urandom_range(6, 1)) frame_buf.push_back(8'($urandom));
        end
        if ($urandom_range(99) < 35) begin
            frame_buf.push_back(NUL_BYTE);
        end
        add_tail();
        commit_frame();
    endtask

    task automatic random_noise();
        int unsigned n;
        n = $urandom_range(30, 1);
        repeat (n) frame_buf.push_back(8'($urandom));
        if ($urandom_range(1) == 0) begin
            frame_buf[0] = SOF_BYTE;
        end
        if (n > 1 && $urandom_range(3) == 0) begin
            frame_buf[1] = RTC_CMD;
        end
        commit_frame();
    endtask

    task automatic set_pressure(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
        endcase
    endtask

    task automatic write_screen_filter(input logic [15:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(REG_SCREEN_FILTER) << CFG_IDX_LSB;
        pwdata  <= {16'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        filter_now = v;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (uplink_bytes.size() != 0 || in_if.valid || frame_verdicts.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : run_phases
        logic [15:0] filt;
        int          start;
        int unsigned r;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_if.valid      = 1'b0;
        in_if.frame_byte = '0;
        in_if.frame_end  = 1'b0;
        out_if.ready     = 1'b0;
        reset_decoder();
        set_pressure(0);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_screen_filter(16'hA55A);
        rtc_frame(SOF_BYTE, 8'h00, 8'h01, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00, 0);
        rtc_frame(SOF_BYTE, 8'h99, 8'h12, 8'h06, 8'h31, 8'h23, 8'h59, 8'h59, 0);
        rtc_frame(SOF_BYTE, 8'h24, 8'h13, 8'h01, 8'h10, 8'h10, 8'h10, 8'h10, 0);
        rtc_frame(SOF_BYTE, 8'hA5, 8'h05, 8'h01, 8'h10, 8'h10, 8'h5A, 8'h10, 0);
        rtc_frame(SOF_BYTE, 8'h25, 8'h06, 8'h02, 8'h15, 8'h08, 8'h30, 8'h00, -1);
        rtc_frame(SOF_BYTE, 8'h25, 8'h06, 8'h02, 8'h15, 8'h08, 8'h30, 8'h00, 1);
        rtc_frame(8'hEF, 8'h25, 8'h06, 8'h02, 8'h15, 8'h08, 8'h30, 8'h00, 0);
        notify_frame(16'hA55A, CTRL_YEAR, 65535, 0, 1'b0);
        notify_frame(16'hA55A, CTRL_MONTH, 300, 0, 1'b1);
        notify_frame(16'hA55A, CTRL_DAY, 65535, 3, 1'b0);
        notify_frame(16'hA55A, CTRL_HOUR, 65536, 0, 1'b0);
        notify_frame(16'hA55A, CTRL_MINUTE, 0, 0, 1'b1);
        notify_frame(16'hA55A, 16'd7, 42, 0, 1'b0);
        notify_frame(16'hA55A, 16'hFFFF, 0, 0, 1'b0);
        notify_frame(16'h5AA5, CTRL_YEAR, 1, 0, 1'b0);
        // An empty text, a frame with no text at all and a stray NUL byte inside the digits.
        add_head(16'hA55A, CTRL_YEAR);
        frame_buf.push_back(NUL_BYTE);
        add_tail();
        commit_frame();
        add_head(16'hA55A, CTRL_YEAR);
        add_tail();
        commit_frame();
        add_head(16'hA55A, CTRL_DAY);
        frame_buf.push_back(ASCII_ZERO + 8'd1);
        frame_buf.push_back(NUL_BYTE);
        frame_buf.push_back(ASCII_ZERO + 8'd2);
        add_tail();
        commit_frame();
        frame_buf.push_back(RTC_CMD);
        commit_frame();
        frame_buf.push_back(SOF_BYTE);
        frame_buf.push_back(RTC_CMD);
        commit_frame();
        long_notify(MAX_FRAME_BYTES);
        long_notify(MAX_FRAME_BYTES + 2);
        notify_frame(16'hA55A, CTRL_YEAR, 2026, 0, 1'b0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            set_pressure(ph % 4);
            case (ph)
                0: filt = 16'h0000;
                1: filt = 16'hFFFF;
                3: filt = 16'h0001;
                4: filt = 16'h8000;
                default: filt = 16'($urandom);
            endcase
            write_screen_filter(filt);
            start = bytes_queued;
            while (bytes_queued - start < PHASE_BYTES) begin
                r = $urandom_range(99);
                if (r < 45) begin
                    random_notify();
                end else if (r < 80) begin
                    random_rtc();
                end else begin
                    random_noise();
                end
            end
            drain();
        end

        mismatches += frame_verdicts.size();
        $display("Run covered %0d bytes in %0d frames, nine screen filter settings and four",
                 bytes_taken, frames_queued);
        $display("handshake pressure modes: %0d clock stores, %0d query updates,",
                 status_seen[ST_RTC], status_seen[ST_QUERY]);
        $display("%0d other and %0d ignored.", status_seen[ST_OTHER],
                 status_seen[ST_IGNORED]);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/hufd_pkg.sv
src/hufd_if.sv
src/hufd_front.sv
src/hufd_fifo.sv
src/hufd_back.sv
src/hmi_uplink_frame_decoder_unit.sv
tb/sv/tb_top.sv
